// File: hw/rtl/sapd_pkg.sv
// shared types, constants and helpers for the setpoint approach pd controller
// no dependencies; used by the channel interfaces, sapd_law and the top level
package sapd_pkg;

    // field widths
    localparam int PosW   = 21;
    localparam int ErrW   = 23;
    localparam int DerW   = 24;
    localparam int GainW  = 16;
    localparam int DriveW = 8;
    localparam int MagW   = 7;
    localparam int MsW    = 8;
    localparam int CmdW   = 2;
    localparam int PhaseW = 2;
    localparam int AddrW  = 5;
    localparam int DataW  = 32;
    localparam int IdxW   = 3;

    // drive saturation limit
    localparam logic signed [DriveW-1:0] DRIVE_MAX = 8'sd127;
    localparam logic signed [DriveW-1:0] DRIVE_MIN = -8'sd127;

    // command codes
    localparam logic [CmdW-1:0] CMD_START  = 2'd0;
    localparam logic [CmdW-1:0] CMD_SAMPLE = 2'd1;
    localparam logic [CmdW-1:0] CMD_TICK   = 2'd2;

    // phase codes on the result
    localparam logic [PhaseW-1:0] PHASE_IDLE    = 2'd0;
    localparam logic [PhaseW-1:0] PHASE_MOVING  = 2'd1;
    localparam logic [PhaseW-1:0] PHASE_BRAKING = 2'd2;

    // register indexes (byte address is 4 * index)
    localparam logic [IdxW-1:0] REG_SETPOINT    = 3'd0;
    localparam logic [IdxW-1:0] REG_KP_Q8       = 3'd1;
    localparam logic [IdxW-1:0] REG_KD_Q8       = 3'd2;
    localparam logic [IdxW-1:0] REG_MIN_DRIVE   = 3'd3;
    localparam logic [IdxW-1:0] REG_BRAKE_DRIVE = 3'd4;
    localparam logic [IdxW-1:0] REG_BRAKE_MS    = 3'd5;

    // register reset values (kp 49 is about 0.19 in q8.8)
    localparam logic signed [PosW-1:0] SETPOINT_RST  = 21'sd0;
    localparam logic [GainW-1:0]       KP_RST        = 16'd49;
    localparam logic [GainW-1:0]       KD_RST        = 16'd0;
    localparam logic [MagW-1:0]        MIN_DRIVE_RST = 7'd30;
    localparam logic [MagW-1:0]        BRAKE_DRV_RST = 7'd20;
    localparam logic [MsW-1:0]         BRAKE_MS_RST  = 8'd50;

    // controller mode
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_MOVING  = 3'b010,
        MODE_BRAKING = 3'b100
    } mode_t;

    // configuration register set
    typedef struct packed {
        logic signed [PosW-1:0] setpoint;
        logic [GainW-1:0]       kp_q8;
        logic [GainW-1:0]       kd_q8;
        logic [MagW-1:0]        min_drive;
        logic [MagW-1:0]        brake_drive;
        logic [MsW-1:0]         brake_ms;
    } cfg_t;

    // mode to phase code
    function automatic logic [PhaseW-1:0] phase_of(input mode_t m);
        logic [PhaseW-1:0] p;
        case (m)
            MODE_IDLE:    p = PHASE_IDLE;
            MODE_MOVING:  p = PHASE_MOVING;
            MODE_BRAKING: p = PHASE_BRAKING;
            default:      p = PHASE_IDLE;
        endcase
        return p;
    endfunction

endpackage

// File: hw/rtl/sapd_in_if.sv
// input channel of the setpoint approach pd controller: command and position beats
// depends on sapd_pkg
interface sapd_in_if;
    logic                             valid;
    logic                             ready;
    logic [sapd_pkg::CmdW-1:0]        cmd;
    logic signed [sapd_pkg::PosW-1:0] position;

    modport source (output valid, output cmd, output position, input ready);
    modport sink   (input valid, input cmd, input position, output ready);
endinterface

// File: hw/rtl/sapd_out_if.sv
// result channel of the setpoint approach pd controller: drive, phase and done beats
// depends on sapd_pkg
interface sapd_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sapd_pkg::DriveW-1:0] drive;
    logic [sapd_pkg::PhaseW-1:0]        phase;
    logic                               done_res;

    modport source (output valid, output drive, output phase, output done_res, input ready);
    modport sink   (input valid, input drive, input phase, input done_res, output ready);
endinterface

// File: hw/rtl/setpoint_approach_pd.sv
// Setpoint approach pd controller: move-to-setpoint drive with least drive and
// timed reverse brake after overshoot.
//
// Channels: in_ch carries beats of cmd (start, sample, millisecond tick) and
// position; out_ch returns exactly one beat of drive, phase and done_res per
// input beat, in order. Both use valid/ready, a beat moves when both are high.
// Registers are written over the apb port (4*index byte addresses): setpoint,
// kp_q8, kd_q8, min_drive, brake_drive, brake_ms; write them only while idle.
//
// Flow: an accepted beat lands in the input register, is worked by the pd law
// (two multipliers in parallel) and goes into the result register, from which
// it is offered on out_ch. Throughput: one beat per cycle while out_ch does not
// stall; the controller state is updated between consecutive items as each fires.
// When out_ch stalls, the result register holds and the input register takes
// one more beat before in_ch.ready drops; nothing is lost or repeated.
// Reset clears the pipeline, returns the controller to idle with zeroed state
// and loads the register defaults.
// depends on sapd_pkg, sapd_in_if, sapd_out_if and sapd_law
module setpoint_approach_pd (
    input  logic                               clk,
    input  logic                               rst_n,
    sapd_in_if.sink                            in_ch,
    sapd_out_if.source                         out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sapd_pkg::AddrW-1:0]         paddr,
    input  logic [sapd_pkg::DataW-1:0]         pwdata,
    output logic [sapd_pkg::DataW-1:0]         prdata,
    output logic                               pready
);

    sapd_pkg::cfg_t                     cfg_reg;
    logic [sapd_pkg::IdxW-1:0]          reg_idx;
    logic                               cfg_wr;

    logic                               in_valid_reg;
    logic [sapd_pkg::CmdW-1:0]          in_cmd_reg;
    logic signed [sapd_pkg::PosW-1:0]   in_pos_reg;

    logic                               out_valid_reg;
    logic signed [sapd_pkg::DriveW-1:0] out_drive_reg;
    logic [sapd_pkg::PhaseW-1:0]        out_phase_reg;
    logic                               out_done_reg;

    sapd_pkg::mode_t                    mode_reg, mode_next;
    logic signed [sapd_pkg::PosW-1:0]   origin_reg, origin_next;
    logic signed [sapd_pkg::ErrW-1:0]   prev_err_reg, prev_err_next;
    logic                               reverse_reg, reverse_next;
    logic [sapd_pkg::MsW-1:0]           brake_rem_reg, brake_rem_next;
    logic signed [sapd_pkg::DriveW-1:0] held_reg, held_next;
    logic                               done_next;

    logic                               advance;
    logic                               fire;
    logic signed [sapd_pkg::ErrW-1:0]   law_err;
    logic signed [sapd_pkg::DriveW-1:0] law_drive;
    logic signed [sapd_pkg::DriveW-1:0] brake_pos;
    logic                               overshoot;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[sapd_pkg::AddrW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint    <= sapd_pkg::SETPOINT_RST;
            cfg_reg.kp_q8       <= sapd_pkg::KP_RST;
            cfg_reg.kd_q8       <= sapd_pkg::KD_RST;
            cfg_reg.min_drive   <= sapd_pkg::MIN_DRIVE_RST;
            cfg_reg.brake_drive <= sapd_pkg::BRAKE_DRV_RST;
            cfg_reg.brake_ms    <= sapd_pkg::BRAKE_MS_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                sapd_pkg::REG_SETPOINT:    cfg_reg.setpoint    <= pwdata[sapd_pkg::PosW-1:0];
                sapd_pkg::REG_KP_Q8:       cfg_reg.kp_q8       <= pwdata[sapd_pkg::GainW-1:0];
                sapd_pkg::REG_KD_Q8:       cfg_reg.kd_q8       <= pwdata[sapd_pkg::GainW-1:0];
                sapd_pkg::REG_MIN_DRIVE:   cfg_reg.min_drive   <= pwdata[sapd_pkg::MagW-1:0];
                sapd_pkg::REG_BRAKE_DRIVE: cfg_reg.brake_drive <= pwdata[sapd_pkg::MagW-1:0];
                sapd_pkg::REG_BRAKE_MS:    cfg_reg.brake_ms    <= pwdata[sapd_pkg::MsW-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (reg_idx)
            sapd_pkg::REG_SETPOINT:    prdata = {11'd0, cfg_reg.setpoint};
            sapd_pkg::REG_KP_Q8:       prdata = {16'd0, cfg_reg.kp_q8};
            sapd_pkg::REG_KD_Q8:       prdata = {16'd0, cfg_reg.kd_q8};
            sapd_pkg::REG_MIN_DRIVE:   prdata = {25'd0, cfg_reg.min_drive};
            sapd_pkg::REG_BRAKE_DRIVE: prdata = {25'd0, cfg_reg.brake_drive};
            sapd_pkg::REG_BRAKE_MS:    prdata = {24'd0, cfg_reg.brake_ms};
            default:                   prdata = '0;
        endcase
    end

    // handshake: result register frees when empty or taken
    assign advance     = !out_valid_reg || out_ch.ready;
    assign fire        = in_valid_reg && advance;
    assign in_ch.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_cmd_reg <= in_ch.cmd;
            in_pos_reg <= in_ch.position;
        end
    end

    // pd law on the held item
    sapd_law u_law (
        .cfg        (cfg_reg),
        .position   (in_pos_reg),
        .origin     (origin_reg),
        .prev_error (prev_err_reg),
        .reverse    (reverse_reg),
        .error      (law_err),
        .drive      (law_drive)
    );

    assign brake_pos = {1'b0, cfg_reg.brake_drive};
    assign overshoot = reverse_reg ? (!law_err[sapd_pkg::ErrW-1] && (|law_err))
                                   : law_err[sapd_pkg::ErrW-1];

    // controller state update
    always_comb
    begin
        mode_next      = mode_reg;
        origin_next    = origin_reg;
        prev_err_next  = prev_err_reg;
        reverse_next   = reverse_reg;
        brake_rem_next = brake_rem_reg;
        held_next      = held_reg;
        done_next      = 1'b0;
        case (in_cmd_reg)
            sapd_pkg::CMD_START:
            begin
                origin_next    = in_pos_reg;
                prev_err_next  = '0;
                reverse_next   = cfg_reg.setpoint[sapd_pkg::PosW-1];
                brake_rem_next = '0;
                held_next      = '0;
                mode_next      = sapd_pkg::MODE_MOVING;
            end
            sapd_pkg::CMD_SAMPLE:
            begin
                if (mode_reg == sapd_pkg::MODE_MOVING)
                begin
                    prev_err_next = law_err;
                    if (overshoot)
                    begin
                        held_next      = reverse_reg ? brake_pos : -brake_pos;
                        brake_rem_next = cfg_reg.brake_ms;
                        mode_next      = sapd_pkg::MODE_BRAKING;
                    end
                    else
                    begin
                        held_next = law_drive;
                    end
                end
            end
            sapd_pkg::CMD_TICK:
            begin
                if (mode_reg == sapd_pkg::MODE_BRAKING)
                begin
                    if (brake_rem_reg <= sapd_pkg::MsW'(1))
                    begin
                        brake_rem_next = '0;
                        held_next      = '0;
                        mode_next      = sapd_pkg::MODE_IDLE;
                        done_next      = 1'b1;
                    end
                    else
                    begin
                        brake_rem_next = brake_rem_reg - sapd_pkg::MsW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= sapd_pkg::MODE_IDLE;
            origin_reg    <= '0;
            prev_err_reg  <= '0;
            reverse_reg   <= 1'b0;
            brake_rem_reg <= '0;
            held_reg      <= '0;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            origin_reg    <= origin_next;
            prev_err_reg  <= prev_err_next;
            reverse_reg   <= reverse_next;
            brake_rem_reg <= brake_rem_next;
            held_reg      <= held_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_drive_reg <= held_next;
            out_phase_reg <= sapd_pkg::phase_of(mode_next);
            out_done_reg  <= done_next;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.drive    = out_drive_reg;
    assign out_ch.phase    = out_phase_reg;
    assign out_ch.done_res = out_done_reg;

endmodule

// File: hw/rtl/sapd_law.sv
// pd drive law: position error, derivative term, q8.8 gains, truncation,
// saturation and least drive in the direction of travel; depends on sapd_pkg
module sapd_law (
    input  sapd_pkg::cfg_t                    cfg,
    input  logic signed [sapd_pkg::PosW-1:0]  position,
    input  logic signed [sapd_pkg::PosW-1:0]  origin,
    input  logic signed [sapd_pkg::ErrW-1:0]  prev_error,
    input  logic                              reverse,
    output logic signed [sapd_pkg::ErrW-1:0]  error,
    output logic signed [sapd_pkg::DriveW-1:0] drive
);

    localparam int ProdPW = sapd_pkg::ErrW + sapd_pkg::GainW + 1;
    localparam int ProdDW = sapd_pkg::DerW + sapd_pkg::GainW + 1;
    localparam int SumW   = ProdDW + 1;
    localparam int QuotW  = SumW - 8;

    logic signed [sapd_pkg::ErrW-1:0]   pos_x;
    logic signed [sapd_pkg::ErrW-1:0]   org_x;
    logic signed [sapd_pkg::ErrW-1:0]   sp_x;
    logic signed [sapd_pkg::DerW-1:0]   der;
    logic signed [sapd_pkg::GainW:0]    kp_s;
    logic signed [sapd_pkg::GainW:0]    kd_s;
    logic signed [ProdPW-1:0]           p_prod;
    logic signed [ProdDW-1:0]           d_prod;
    logic signed [SumW-1:0]             sum;
    logic signed [QuotW-1:0]            quot;
    logic signed [sapd_pkg::DriveW-1:0] sat;
    logic signed [sapd_pkg::DriveW-1:0] mn_pos;
    logic signed [sapd_pkg::DriveW-1:0] mn_neg;

    // error relative to the origin, exact in 23 bits
    assign pos_x = {{2{position[sapd_pkg::PosW-1]}}, position};
    assign org_x = {{2{origin[sapd_pkg::PosW-1]}}, origin};
    assign sp_x  = {{2{cfg.setpoint[sapd_pkg::PosW-1]}}, cfg.setpoint};
    assign error = sp_x - (pos_x - org_x);
    assign der   = {error[sapd_pkg::ErrW-1], error}
                 - {prev_error[sapd_pkg::ErrW-1], prev_error};

    // gain products, gains taken as non-negative signed
    assign kp_s   = {1'b0, cfg.kp_q8};
    assign kd_s   = {1'b0, cfg.kd_q8};
    assign p_prod = error * kp_s;
    assign d_prod = der * kd_s;
    assign sum    = {{(SumW-ProdPW){p_prod[ProdPW-1]}}, p_prod}
                  + {d_prod[ProdDW-1], d_prod};

    // divide by 256 truncating toward zero
    assign quot = sum[SumW-1:8] + QuotW'(sum[SumW-1] && (|sum[7:0]));

    // saturate and lift to the least drive
    assign mn_pos = {1'b0, cfg.min_drive};
    assign mn_neg = -mn_pos;

    always_comb
    begin
        if (quot > QuotW'(sapd_pkg::DRIVE_MAX))
        begin
            sat = sapd_pkg::DRIVE_MAX;
        end
        else if (quot < QuotW'(sapd_pkg::DRIVE_MIN))
        begin
            sat = sapd_pkg::DRIVE_MIN;
        end
        else
        begin
            sat = quot[sapd_pkg::DriveW-1:0];
        end

        drive = sat;
        if (!reverse && (sat < mn_pos))
        begin
            drive = mn_pos;
        end
        if (reverse && (sat > mn_neg))
        begin
            drive = mn_neg;
        end
    end

endmodule
